FILE: design/wpd_pkg.sv
// shared types, codes and defaults for the worker pool dispatcher
package wpd_pkg;

  localparam int WPD_MAX_WORKERS  = 16;
  localparam int WPD_QUEUE_DEPTH  = 64;
  localparam int WPD_TIME_BITS    = 48;
  localparam int WPD_ACTIVE_RESET = 4;

  localparam int ID_W    = 5;
  localparam int REQ_W   = 32;
  localparam int NOW_W   = 48;
  localparam int QLEN_W  = 7;

  // event kinds on the input channel
  localparam logic [1:0] KIND_ARRIVAL = 2'd0;
  localparam logic [1:0] KIND_STAGE   = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // operations passed from front to back
  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_STAGE  = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // result actions
  localparam logic [2:0] ACT_START    = 3'd0;
  localparam logic [2:0] ACT_QUEUED   = 3'd1;
  localparam logic [2:0] ACT_FORWARD  = 3'd2;
  localparam logic [2:0] ACT_COMPLETE = 3'd3;
  localparam logic [2:0] ACT_DROPPED  = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [REQ_W-1:0] request_id;
    logic [ID_W-1:0]  worker_id;
    logic [NOW_W-1:0] now;
  } wpd_in_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [REQ_W-1:0]  out_request_id;
    logic [ID_W-1:0]   out_worker_id;
    logic [NOW_W-1:0]  elapsed;
    logic [QLEN_W-1:0] queue_length;
    logic              last;
  } wpd_out_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [REQ_W-1:0] request_id;
    logic [ID_W-1:0]  worker_id;
    logic [NOW_W-1:0] now;
  } wpd_op_t;

  // handshake between front queue and back engine
  typedef struct packed {
    logic pop;
  } wpd_q_ctl_t;

endpackage

FILE: design/worker_pool_dispatcher_top.sv
// top level of the worker pool dispatcher
//
//  channel | ports                          | direction | beat
//  --------+--------------------------------+-----------+----------------------------------
//  in      | in_valid, in_stall, in_data    | into      | one event (kind, request, worker, now)
//  out     | out_valid, out_stall, out_data | out of    | one result; last marks the final one
//  cfg     | cfg_valid, cfg_ready, cfg_data | into      | active worker count
//
// in the back end each event first reads the wait fifo head and the arrival time memory,
// then updates state and loads the result register once the output is free; an end event
// that hands its worker to a waiting request loads its second result in a further state.
// a two-beat event queue sits between the front and back ends; in_stall rises when it is full.
// reset is synchronous on rst_n; the free list refills at once, with no clearing pass.
// cfg_ready is always high; a write refills the free list and keeps the wait fifo.
module worker_pool_dispatcher_top
  import wpd_pkg::*;
#(
  parameter int MAX_WORKERS = WPD_MAX_WORKERS,
  parameter int QUEUE_DEPTH = WPD_QUEUE_DEPTH,
  parameter int TIME_BITS   = WPD_TIME_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wpd_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output wpd_out_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ID_W-1:0] cfg_data
);

  logic       q_valid;
  wpd_q_ctl_t q_ctl;
  wpd_op_t    q_data;

  wpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ctl    (q_ctl),
    .q_data   (q_data)
  );

  wpd_back #(
    .MAX_WORKERS (MAX_WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ctl     (q_ctl),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/wpd_ram.sv
// generic single write port ram with registered read
module wpd_ram
  import wpd_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                                wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                                rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/wpd_front.sv
// front end: accepts events, classifies them and queues them for the back end
module wpd_front
  import wpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  wpd_in_t    in_data,
  output logic       q_valid,
  input  wpd_q_ctl_t q_ctl,
  output wpd_op_t    q_data
);

  wpd_op_t    q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       push;
  wpd_op_t    op_in;

  // unknown kinds are dropped here and never reach the back end
  always_comb begin
    keep             = 1'b1;
    op_in.op         = OP_ARRIVE;
    op_in.request_id = in_data.request_id;
    op_in.worker_id  = in_data.worker_id;
    op_in.now        = in_data.now;
    case (in_data.kind)
      KIND_ARRIVAL: op_in.op = OP_ARRIVE;
      KIND_STAGE:   op_in.op = OP_STAGE;
      KIND_END:     op_in.op = OP_END;
      default:      keep = 1'b0;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = q_ctl.pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_ctl.pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= op_in;
    end
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_ctl.pop |-> q_valid)
    else $error("pop from empty event queue");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd2) |=> (cnt_r != 2'd0))
    else $error("full event queue emptied in one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
                   q_ctl.pop |=> (cnt_r != 2'd2) || $past(push))
    else $error("queue count inconsistent with pop");

endmodule

FILE: design/wpd_back.sv
// back end: free list, wait fifo, arrival times and result register
module wpd_back
  import wpd_pkg::*;
#(
  parameter int MAX_WORKERS = WPD_MAX_WORKERS,
  parameter int QUEUE_DEPTH = WPD_QUEUE_DEPTH,
  parameter int TIME_BITS   = WPD_TIME_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ID_W-1:0] cfg_data,
  input  logic            q_valid,
  output wpd_q_ctl_t      q_ctl,
  input  wpd_op_t         q_data,
  output logic            out_valid,
  input  logic            out_stall,
  output wpd_out_t        out_data
);

  localparam int FL_AW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int FL_SW  = ((FL_AW > ID_W) ? FL_AW : ID_W) + 1;
  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QS_W   = QC_W + 1;
  localparam int WQ_W   = REQ_W + TIME_BITS;
  localparam int ACT_RST = (WPD_ACTIVE_RESET > MAX_WORKERS) ? MAX_WORKERS : WPD_ACTIVE_RESET;
  localparam logic [63:0] TMASK = {64{1'b1}} >> (64 - TIME_BITS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SECOND = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [ID_W-1:0]  active_r, active_nxt;
  logic [ID_W-1:0]  fl_r [MAX_WORKERS];
  logic             flv_r [MAX_WORKERS];
  logic [FL_AW-1:0] fl_head_r, fl_head_nxt;
  logic [ID_W-1:0]  fl_cnt_r, fl_cnt_nxt;
  logic [QA_W-1:0]  wq_head_r, wq_head_nxt;
  logic [QC_W-1:0]  wq_cnt_r, wq_cnt_nxt;
  wpd_op_t          cur_r;
  wpd_out_t         pend_r, pend_nxt;
  logic             out_valid_r;
  wpd_out_t         out_data_r;

  logic             cfg_wr;
  logic [ID_W-1:0]  cfg_clamped;
  logic             out_free;
  logic             load;
  wpd_out_t         res;
  logic             fl_push;
  logic [ID_W-1:0]  fl_rd;
  logic [FL_SW-1:0] fl_sum;
  logic [FL_AW-1:0] fl_tail;
  logic [QS_W-1:0]  wq_sum;
  logic [QA_W-1:0]  wq_tail;
  logic             wvalid;
  logic [ID_W-1:0]  start_w;

  logic             t_we;
  logic [FL_AW-1:0] t_waddr, t_raddr;
  logic [TIME_BITS-1:0] t_wdata, t_rdata, now_t;
  logic             w_we;
  logic [WQ_W-1:0]  w_rdata;
  logic [REQ_W-1:0] w_req;
  logic [TIME_BITS-1:0] w_time;

  function automatic logic [FL_AW-1:0] tidx(input logic [ID_W-1:0] wid);
    logic [ID_W-1:0] d;
    d = wid - 1'b1;
    return FL_AW'(d);
  endfunction

  wpd_ram #(.W(TIME_BITS), .DEPTH(MAX_WORKERS)) u_time_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  wpd_ram #(.W(WQ_W), .DEPTH(QUEUE_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (wq_tail),
    .wdata ({cur_r.request_id, now_t}),
    .raddr (wq_head_r),
    .rdata (w_rdata)
  );

  assign w_req  = w_rdata[WQ_W-1 -: REQ_W];
  assign w_time = w_rdata[TIME_BITS-1:0];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = ID_W'(1);
    end else if (32'(cfg_data) > MAX_WORKERS) begin
      cfg_clamped = ID_W'(MAX_WORKERS);
    end
  end

  assign out_free    = !out_valid_r || !out_stall;
  assign q_ctl.pop   = (state_r == S_IDLE) && q_valid;
  // hold the read address on the current item while the result register is busy
  assign t_raddr     = (state_r == S_IDLE) ? tidx(q_data.worker_id) : tidx(cur_r.worker_id);

  // free list: an entry not rewritten since the last refill holds its index plus one
  assign fl_rd   = flv_r[fl_head_r] ? fl_r[fl_head_r] : ID_W'(FL_SW'(fl_head_r) + 1'b1);
  assign fl_sum  = FL_SW'(fl_head_r) + FL_SW'(fl_cnt_r);
  assign fl_tail = (fl_sum >= FL_SW'(MAX_WORKERS)) ? FL_AW'(fl_sum - FL_SW'(MAX_WORKERS))
                                                   : FL_AW'(fl_sum);
  assign wq_sum  = QS_W'(wq_head_r) + QS_W'(wq_cnt_r);
  assign wq_tail = (wq_sum >= QS_W'(QUEUE_DEPTH)) ? QA_W'(wq_sum - QS_W'(QUEUE_DEPTH))
                                                  : QA_W'(wq_sum);

  assign now_t  = TIME_BITS'(64'(cur_r.now) & TMASK);
  assign wvalid = (cur_r.worker_id != '0) && (cur_r.worker_id <= active_r)
                  && (32'(cur_r.worker_id) <= MAX_WORKERS);
  assign start_w = fl_rd;

  always_comb begin
    state_nxt   = state_r;
    active_nxt  = active_r;
    fl_head_nxt = fl_head_r;
    fl_cnt_nxt  = fl_cnt_r;
    wq_head_nxt = wq_head_r;
    wq_cnt_nxt  = wq_cnt_r;
    pend_nxt    = pend_r;
    load        = 1'b0;
    fl_push     = 1'b0;
    t_we        = 1'b0;
    t_waddr     = tidx(cur_r.worker_id);
    t_wdata     = now_t;
    w_we        = 1'b0;
    res.action         = ACT_COMPLETE;
    res.out_request_id = cur_r.request_id;
    res.out_worker_id  = cur_r.worker_id;
    res.elapsed        = '0;
    res.queue_length   = QLEN_W'(wq_cnt_r);
    res.last           = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          case (cur_r.op)
            OP_ARRIVE: begin
              if (fl_cnt_r != '0) begin
                fl_head_nxt = (fl_head_r == FL_AW'(MAX_WORKERS - 1)) ? '0 : fl_head_r + 1'b1;
                fl_cnt_nxt  = fl_cnt_r - 1'b1;
                t_we        = (start_w != '0) && (32'(start_w) <= MAX_WORKERS);
                t_waddr     = tidx(start_w);
                res.action        = ACT_START;
                res.out_worker_id = start_w;
              end else if (32'(wq_cnt_r) < QUEUE_DEPTH) begin
                w_we       = 1'b1;
                wq_cnt_nxt = wq_cnt_r + 1'b1;
                res.action        = ACT_QUEUED;
                res.out_worker_id = '0;
                res.queue_length  = QLEN_W'(wq_cnt_nxt);
              end else begin
                res.action        = ACT_DROPPED;
                res.out_worker_id = '0;
              end
            end
            OP_STAGE: begin
              res.action = ACT_FORWARD;
              if (wvalid) begin
                res.elapsed = NOW_W'((64'(cur_r.now) - 64'(t_rdata)) & TMASK);
              end
            end
            OP_END: begin
              if (wvalid && (wq_cnt_r != '0)) begin
                // freed worker goes straight to the oldest waiting request
                t_we        = 1'b1;
                t_wdata     = w_time;
                wq_head_nxt = (wq_head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wq_head_r + 1'b1;
                wq_cnt_nxt  = wq_cnt_r - 1'b1;
                res.queue_length = QLEN_W'(wq_cnt_nxt);
                res.last         = 1'b0;
                pend_nxt.action         = ACT_START;
                pend_nxt.out_request_id = w_req;
                pend_nxt.out_worker_id  = cur_r.worker_id;
                pend_nxt.elapsed        = '0;
                pend_nxt.queue_length   = QLEN_W'(wq_cnt_nxt);
                pend_nxt.last           = 1'b1;
                state_nxt = S_SECOND;
              end else if (wvalid && (fl_cnt_r < active_r)
                           && (32'(fl_cnt_r) < MAX_WORKERS)) begin
                fl_push    = 1'b1;
                fl_cnt_nxt = fl_cnt_r + 1'b1;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      S_SECOND: begin
        if (out_free) begin
          load      = 1'b1;
          res       = pend_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      active_nxt  = cfg_clamped;
      fl_head_nxt = '0;
      fl_cnt_nxt  = cfg_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctl.pop) begin
      cur_r <= q_data;
    end
    pend_r <= pend_nxt;
    if (fl_push) begin
      fl_r[fl_tail] <= cur_r.worker_id;
    end
    if (load) begin
      out_data_r <= res;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ID_W'(ACT_RST);
      fl_head_r   <= '0;
      fl_cnt_r    <= ID_W'(ACT_RST);
      wq_head_r   <= '0;
      wq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        flv_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      fl_head_r   <= fl_head_nxt;
      fl_cnt_r    <= fl_cnt_nxt;
      wq_head_r   <= wq_head_nxt;
      wq_cnt_r    <= wq_cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        for (int i = 0; i < MAX_WORKERS; i++) begin
          flv_r[i] <= 1'b0;
        end
      end else if (fl_push) begin
        flv_r[fl_tail] <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n) fl_cnt_r <= active_r)
    else $error("free list holds more ids than active workers");
  assert property (@(posedge clk) disable iff (!rst_n) 32'(wq_cnt_r) <= QUEUE_DEPTH)
    else $error("wait fifo count over depth");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_SECOND) |-> (out_valid_r && pend_r.last))
    else $error("second result pending without completion in output register");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_EXEC) && load && (state_nxt == S_SECOND) |-> !res.last)
    else $error("completion followed by start marked last");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the worker pool dispatcher: directed events, then random traffic
module testbench;
  import wpd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 16;
  localparam logic [NOW_W-1:0] TICK_MAX = '1;
  // kind code with no meaning, the block must ignore it
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  wpd_in_t         in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  wpd_out_t        out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [ID_W-1:0] cfg_data  = '0;

  worker_pool_dispatcher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // dispatcher state as the testbench sees it
  int unsigned      pool_size;
  logic [ID_W-1:0]  free_ids [WPD_MAX_WORKERS];
  int unsigned      free_cnt;
  int unsigned      free_head;
  logic [REQ_W-1:0] wait_req [WPD_QUEUE_DEPTH];
  logic [NOW_W-1:0] wait_arr [WPD_QUEUE_DEPTH];
  int unsigned      wait_head;
  int unsigned      wait_cnt;
  logic [NOW_W-1:0] arrived_at  [1:WPD_MAX_WORKERS];
  bit               arrived_set [1:WPD_MAX_WORKERS];
  logic [REQ_W-1:0] serving_req [1:WPD_MAX_WORKERS];
  wpd_out_t         pending_results [$];

  logic [NOW_W-1:0] tick = '0;
  int               errors = 0;
  int               cycle_count = 0;
  bit               offering = 1'b0;
  bit               idle_on = 1'b1;
  bit               stall_on = 1'b0;
  int unsigned      stall_left = 0;
  int unsigned      hold_req = 0;
  int unsigned      hold_left = 0;
  wpd_out_t         want_beat;

  function automatic void refill_free_list();
    for (int i = 0; i < WPD_MAX_WORKERS; i++)
      free_ids[i] = (i < pool_size) ? ID_W'(i + 1) : '0;
    free_cnt  = pool_size;
    free_head = 0;
  endfunction

  function automatic wpd_out_t result_beat(logic [2:0] act, logic [REQ_W-1:0] req,
                                           logic [ID_W-1:0] wid, logic [NOW_W-1:0] el,
                                           logic fin);
    wpd_out_t r;
    r.action         = act;
    r.out_request_id = req;
    r.out_worker_id  = wid;
    r.elapsed        = el;
    r.queue_length   = QLEN_W'(wait_cnt);
    r.last           = fin;
    return r;
  endfunction

  // update the state for one accepted event and queue the results it owes
  function automatic void dispatch_event(wpd_in_t ev);
    logic [ID_W-1:0] w;
    int unsigned     slot;
    bit              known;
    known = (ev.worker_id >= 1) && (ev.worker_id <= pool_size);
    w = ev.worker_id;
    case (ev.kind)
      KIND_ARRIVAL: begin
        if (free_cnt > 0) begin
          w = free_ids[free_head];
          free_head = (free_head + 1) % WPD_MAX_WORKERS;
          free_cnt--;
          arrived_at[w]  = ev.now;
          arrived_set[w] = 1'b1;
          serving_req[w] = ev.request_id;
          pending_results.push_back(result_beat(ACT_START, ev.request_id, w, '0, 1'b1));
        end else if (wait_cnt < WPD_QUEUE_DEPTH) begin
          slot = (wait_head + wait_cnt) % WPD_QUEUE_DEPTH;
          wait_req[slot] = ev.request_id;
          wait_arr[slot] = ev.now;
          wait_cnt++;
          pending_results.push_back(result_beat(ACT_QUEUED, ev.request_id, '0, '0, 1'b1));
        end else begin
          pending_results.push_back(result_beat(ACT_DROPPED, ev.request_id, '0, '0, 1'b1));
        end
      end
      KIND_STAGE: begin
        pending_results.push_back(result_beat(ACT_FORWARD, ev.request_id, w,
            known ? NOW_W'(ev.now - arrived_at[w]) : '0, 1'b1));
      end
      KIND_END: begin
        if (!known) begin
          pending_results.push_back(result_beat(ACT_COMPLETE, ev.request_id, w, '0, 1'b1));
        end else if (wait_cnt > 0) begin
          // freed worker goes straight to the oldest waiting request
          slot = wait_head;
          arrived_at[w]  = wait_arr[slot];
          arrived_set[w] = 1'b1;
          serving_req[w] = wait_req[slot];
          wait_head = (wait_head + 1) % WPD_QUEUE_DEPTH;
          wait_cnt--;
          pending_results.push_back(result_beat(ACT_COMPLETE, ev.request_id, w, '0, 1'b0));
          pending_results.push_back(result_beat(ACT_START, wait_req[slot], w, '0, 1'b1));
        end else begin
          if (free_cnt < pool_size) begin
            free_ids[(free_head + free_cnt) % WPD_MAX_WORKERS] = w;
            free_cnt++;
          end
          pending_results.push_back(result_beat(ACT_COMPLETE, ev.request_id, w, '0, 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic wpd_in_t ev_of(logic [1:0] k, logic [REQ_W-1:0] req,
                                    logic [ID_W-1:0] wid, logic [NOW_W-1:0] t);
    wpd_in_t ev;
    ev.kind       = k;
    ev.request_id = req;
    ev.worker_id  = wid;
    ev.now        = t;
    return ev;
  endfunction

  function automatic logic [NOW_W-1:0] next_now();
    if ($urandom_range(99) < 4)
      tick = NOW_W'({$urandom(), $urandom()});
    else
      tick = tick + NOW_W'($urandom_range(500));
    return tick;
  endfunction

  // random worker that is out of the free list, 0 when every worker is idle
  function automatic int unsigned pick_busy();
    int unsigned cand [WPD_MAX_WORKERS];
    int unsigned n;
    bit          listed;
    n = 0;
    for (int unsigned w = 1; w <= pool_size; w++) begin
      listed = 1'b0;
      for (int unsigned j = 0; j < free_cnt; j++)
        if (free_ids[(free_head + j) % WPD_MAX_WORKERS] == w) listed = 1'b1;
      if (!listed) begin
        cand[n] = w;
        n++;
      end
    end
    return (n == 0) ? 0 : cand[$urandom_range(n - 1)];
  endfunction

  function automatic wpd_in_t gen_event(int unsigned arr_pct);
    wpd_in_t     ev;
    int unsigned r;
    int unsigned w;
    r = $urandom_range(99);
    ev.kind       = KIND_ARRIVAL;
    ev.request_id = $urandom();
    ev.worker_id  = ID_W'($urandom());
    ev.now        = next_now();
    w = pick_busy();
    if (r < 8) begin
      // noise: any kind, any worker id
      ev.kind = 2'($urandom());
      if (ev.kind == KIND_STAGE && ev.worker_id >= 1 && ev.worker_id <= pool_size &&
          !arrived_set[ev.worker_id])
        ev.worker_id = '0;
    end else if (r >= 8 + arr_pct && w != 0) begin
      ev.kind = ($urandom_range(99) < 40 && arrived_set[w]) ? KIND_STAGE : KIND_END;
      ev.worker_id  = ID_W'(w);
      ev.request_id = serving_req[w];
    end
    return ev;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_event(input wpd_in_t ev, input int unsigned gap);
    in_valid <= 1'b1;
    in_data  <= ev;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dispatch_event(ev);
    if (gap > 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pool(input logic [ID_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_size = (value == 0) ? 1 : (value > WPD_MAX_WORKERS) ? WPD_MAX_WORKERS : value;
    refill_free_list();
  endtask

  task automatic run_items(input int unsigned n, input int unsigned arr_pct);
    repeat (n) send_event(gen_event(arr_pct), pick_gap());
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // receiver stall: random runs, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (stall_left == 0) begin
        stall_on   = idle_on && ($urandom_range(99) < 35);
        stall_left = (stall_on && $urandom_range(99) < 10) ? $urandom_range(40, 10)
                                                           : $urandom_range(4, 1);
      end
      stall_left--;
      out_stall <= stall_on;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want_beat = pending_results.pop_front();
        check_field("action", 64'(want_beat.action), 64'(out_data.action));
        check_field("request_id", 64'(want_beat.out_request_id),
                    64'(out_data.out_request_id));
        check_field("worker_id", 64'(want_beat.out_worker_id), 64'(out_data.out_worker_id));
        check_field("elapsed", 64'(want_beat.elapsed), 64'(out_data.elapsed));
        check_field("queue_length", 64'(want_beat.queue_length), 64'(out_data.queue_length));
        check_field("last", 64'(want_beat.last), 64'(out_data.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[worker_pool_dispatcher_top] ERROR");
      $finish;
    end
  end

  // reset pool of four: starts, queueing, wrapped elapsed, bad workers, full free list
  task automatic test_directed();
    send_event(ev_of(KIND_ARRIVAL, 32'h0, 5'd0, '0), pick_gap());
    send_event(ev_of(KIND_ARRIVAL, '1, 5'd31, TICK_MAX), pick_gap());
    send_event(ev_of(KIND_ARRIVAL, 32'h1001, 5'd0, 48'd100), pick_gap());
    send_event(ev_of(KIND_ARRIVAL, 32'h1002, 5'd0, 48'd200), pick_gap());
    send_event(ev_of(KIND_ARRIVAL, 32'h1003, 5'd0, 48'd300), pick_gap());
    send_event(ev_of(KIND_ARRIVAL, 32'h1004, 5'd0, 48'd400), pick_gap());
    send_event(ev_of(KIND_STAGE, 32'h0, 5'd1, TICK_MAX), pick_gap());
    send_event(ev_of(KIND_STAGE, '1, 5'd2, 48'd5), pick_gap());
    send_event(ev_of(KIND_STAGE, 32'h1005, 5'd0, 48'd500), pick_gap());
    send_event(ev_of(KIND_STAGE, 32'h1006, 5'd31, 48'd510), pick_gap());
    send_event(ev_of(KIND_END, 32'h1007, 5'd17, 48'd520), pick_gap());
    send_event(ev_of(KIND_END, 32'h0, 5'd1, 48'd600), pick_gap());
    send_event(ev_of(KIND_STAGE, 32'h1003, 5'd1, 48'd650), pick_gap());
    send_event(ev_of(KIND_END, 32'h1001, 5'd3, 48'd700), pick_gap());
    send_event(ev_of(KIND_UNUSED, 32'h1008, 5'd1, 48'd710), pick_gap());
    send_event(ev_of(KIND_END, 32'h1002, 5'd4, 48'd720), pick_gap());
    send_event(ev_of(KIND_END, '1, 5'd2, 48'd730), pick_gap());
    send_event(ev_of(KIND_END, 32'h1003, 5'd1, 48'd740), pick_gap());
    send_event(ev_of(KIND_END, 32'h1004, 5'd3, 48'd750), pick_gap());
    // free list already full, worker must not go in twice
    send_event(ev_of(KIND_END, 32'h1004, 5'd3, 48'd760), pick_gap());
    send_event(ev_of(KIND_END, 32'h1009, 5'd16, 48'd900), pick_gap());
    send_event(ev_of(KIND_ARRIVAL, 32'h100a, 5'd0, 48'd950), pick_gap());
    send_event(ev_of(KIND_ARRIVAL, 32'h100b, 5'd0, 48'd960), pick_gap());
  endtask

  // single worker, arrival heavy: wait fifo fills and drops appear
  task automatic test_queue_overflow();
    write_pool(5'd0);
    run_items(170, 75);
  endtask

  task automatic test_full_pool();
    write_pool(5'd31);
    run_items(150, 45);
  endtask

  task automatic test_no_idle();
    write_pool(5'd16);
    idle_on = 1'b0;
    run_items(100, 50);
    idle_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits it out
  task automatic test_backpressure();
    write_pool(5'd2);
    hold_req = 300;
    repeat (40) send_event(gen_event(60), 0);
    drain();
    run_items(30, 50);
  endtask

  task automatic test_random_pools();
    repeat (4) begin
      write_pool(ID_W'($urandom()));
      run_items(80, $urandom_range(60, 30));
    end
  endtask

  initial begin
    pool_size = WPD_ACTIVE_RESET;
    refill_free_list();
    wait_head = 0;
    wait_cnt  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_queue_overflow();
    test_full_pool();
    test_no_idle();
    test_backpressure();
    test_random_pools();
    drain();
    if (errors == 0)
      $display("[worker_pool_dispatcher_top] OK");
    else
      $display("[worker_pool_dispatcher_top] ERROR");
    $finish;
  end

endmodule
